// ===== design/tsw_pkg.sv =====
// Shared constants, pipeline payload type and tdata layout of the splat weight blender.
package tsw_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int NUM_MAT     = 4;
  localparam int Q16_BITS    = 17;          // weights in Q0.16 including 1.0
  localparam int RGB_BITS    = 24;
  localparam int NRM_BITS    = 16;
  localparam int DIV_BITS    = 16;          // quotient bits of t
  localparam int DIV_STAGES  = 4;
  localparam int DIV_PER_STG = DIV_BITS / DIV_STAGES;

  localparam logic [Q16_BITS-1:0] ONE_Q16       = Q16_BITS'(65536);
  localparam logic [NRM_BITS-1:0] ONE_Q15       = NRM_BITS'(32768);
  localparam logic [NRM_BITS-1:0] SLOPE_MIN_Q15 = NRM_BITS'(1639);
  localparam logic [7:0]          SCALE_255     = 8'd255;
  localparam logic [1:0]          SLOPE_MAT     = 2'd2;

  // Register indexes of the configuration port
  localparam int CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_0  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_1  = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_2  = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_3  = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOUR_0 = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOUR_1 = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOUR_2 = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOUR_3 = 4'd7;

  // Input tdata layout
  localparam int IN_H_LSB   = 0;
  localparam int IN_N_LSB   = HEIGHT_BITS;
  localparam int IN_T_LSB   = IN_N_LSB + NRM_BITS;
  localparam int IN_RAW     = IN_T_LSB + NUM_MAT * RGB_BITS;
  localparam int IN_TDATA_W = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 80;

  typedef logic [NUM_MAT-1:0][RGB_BITS-1:0] texels_t;

  typedef struct packed {
    logic [1:0]             k;
    logic [NRM_BITS-1:0]    nrm;
    texels_t                tex;
    logic                   div_on;
    logic [HEIGHT_BITS:0]   rem;
    logic [HEIGHT_BITS-1:0] den;
    logic [Q16_BITS-1:0]    quo;
  } pix_t;

endpackage

// ===== design/tsw_band.sv =====
// Band search and division set-up: the first pipeline stage.
module tsw_band (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic                                              in_vld,
  input  logic [tsw_pkg::HEIGHT_BITS-1:0]                   height,
  input  logic [tsw_pkg::NRM_BITS-1:0]                      nrm,
  input  tsw_pkg::texels_t                                  tex,
  input  logic [tsw_pkg::NUM_MAT-1:0][tsw_pkg::HEIGHT_BITS-1:0] bound,
  output logic                                              vld_r,
  output tsw_pkg::pix_t                                     pix_r
);

  tsw_pkg::pix_t                  pix_nxt;
  logic [1:0]                     k;
  logic [tsw_pkg::HEIGHT_BITS-1:0] lo, hi, num, d;

  always_comb begin
    k = 2'd1;
    if (height > bound[1]) k = 2'd2;
    if (height > bound[1] && height > bound[2]) k = 2'd3;
    lo  = bound[k - 2'd1];
    hi  = bound[k];
    num = height - lo;
    d   = hi - lo;
    pix_nxt        = '0;
    pix_nxt.k      = k;
    pix_nxt.nrm    = nrm;
    pix_nxt.tex    = tex;
    pix_nxt.rem    = {1'b0, num};
    pix_nxt.den    = d;
    if (hi > lo && height > lo) begin
      if (num >= d) pix_nxt.quo = tsw_pkg::ONE_Q16;
      else          pix_nxt.div_on = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) pix_r <= pix_nxt;
  end

endmodule

// ===== design/tsw_div_stage.sv =====
// One stage of the restoring divider for t: a few quotient bits per stage.
module tsw_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld,
  input  tsw_pkg::pix_t pix,
  output logic          vld_r,
  output tsw_pkg::pix_t pix_r
);

  tsw_pkg::pix_t            pix_nxt;
  logic [tsw_pkg::HEIGHT_BITS:0] r2;

  always_comb begin
    pix_nxt = pix;
    r2      = '0;
    if (pix.div_on) begin
      for (int i = 0; i < tsw_pkg::DIV_PER_STG; i++) begin
        r2 = {pix_nxt.rem[tsw_pkg::HEIGHT_BITS-1:0], 1'b0};
        if (r2 >= {1'b0, pix_nxt.den}) begin
          pix_nxt.rem = r2 - {1'b0, pix_nxt.den};
          pix_nxt.quo = {pix_nxt.quo[tsw_pkg::Q16_BITS-2:0], 1'b1};
        end else begin
          pix_nxt.rem = r2;
          pix_nxt.quo = {pix_nxt.quo[tsw_pkg::Q16_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld;
    end
    if (en) pix_r <= pix_nxt;
  end

endmodule

// ===== design/tsw_blend.sv =====
// Slope mix, weights, colour products and saturating sums: four pipeline stages.
module tsw_blend (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  logic                                           vld,
  input  tsw_pkg::pix_t                                  pix,
  input  logic [tsw_pkg::NUM_MAT-1:0][tsw_pkg::RGB_BITS-1:0] colour,
  output logic                                           vld_r,
  output logic [tsw_pkg::OUT_TDATA_W-1:0]                data_r
);

  localparam int Q = tsw_pkg::Q16_BITS;
  localparam int P = Q + 8;

  // stage A: slope and scaled band pair
  logic                  va_r;
  logic [1:0]            ka_r;
  tsw_pkg::texels_t      texa_r;
  logic [Q-1:0]          ba_r, ca_r, sa_r;
  logic                  steep;
  logic [Q-1:0]          s_nxt, a_nxt;
  logic [2*Q-1:0]        pb, pc;

  always_comb begin
    steep = (pix.nrm <= tsw_pkg::ONE_Q15) &&
            ((tsw_pkg::ONE_Q15 - pix.nrm) >= tsw_pkg::SLOPE_MIN_Q15);
    s_nxt = steep ? {tsw_pkg::ONE_Q15 - pix.nrm, 1'b0} : '0;
    a_nxt = tsw_pkg::ONE_Q16 - s_nxt;
    pb    = a_nxt * (tsw_pkg::ONE_Q16 - pix.quo);
    pc    = a_nxt * pix.quo;
  end

  // stage B: weights per material
  logic                          vb_r;
  logic [1:0]                    kb_r;
  tsw_pkg::texels_t              texb_r;
  logic [Q-1:0]                  bb_r, cb_r, sb_r;
  logic [tsw_pkg::NUM_MAT-1:0][Q-1:0] wb_r, w_nxt;
  logic [Q:0]                    wsum;

  always_comb begin
    for (int i = 0; i < tsw_pkg::NUM_MAT; i++) begin
      wsum = '0;
      if (2'(i) == ka_r - 2'd1)        wsum = wsum + {1'b0, ba_r};
      if (2'(i) == ka_r)               wsum = wsum + {1'b0, ca_r};
      if (2'(i) == tsw_pkg::SLOPE_MAT) wsum = wsum + {1'b0, sa_r};
      w_nxt[i] = (wsum > {1'b0, tsw_pkg::ONE_Q16}) ? tsw_pkg::ONE_Q16 : wsum[Q-1:0];
    end
  end

  // stage C: products
  logic                          vc_r;
  logic [2:0][2:0][P-1:0]        basep_r;
  logic [2:0][tsw_pkg::NUM_MAT-1:0][P-1:0] splatp_r;
  logic [tsw_pkg::NUM_MAT-1:0][P-1:0] wp_r;
  logic [2:0][2:0][P-1:0]        basep_nxt;
  logic [2:0][tsw_pkg::NUM_MAT-1:0][P-1:0] splatp_nxt;
  logic [tsw_pkg::NUM_MAT-1:0][P-1:0] wp_nxt;
  logic [tsw_pkg::RGB_BITS-1:0]  col_lo, col_hi, col_sl;

  always_comb begin
    col_lo = colour[kb_r - 2'd1];
    col_hi = colour[kb_r];
    col_sl = colour[tsw_pkg::SLOPE_MAT];
    for (int ch = 0; ch < 3; ch++) begin
      basep_nxt[ch][0] = col_lo[16-8*ch +: 8] * bb_r;
      basep_nxt[ch][1] = col_hi[16-8*ch +: 8] * cb_r;
      basep_nxt[ch][2] = col_sl[16-8*ch +: 8] * sb_r;
      for (int i = 0; i < tsw_pkg::NUM_MAT; i++)
        splatp_nxt[ch][i] = texb_r[i][16-8*ch +: 8] * wb_r[i];
    end
    for (int i = 0; i < tsw_pkg::NUM_MAT; i++)
      wp_nxt[i] = tsw_pkg::SCALE_255 * wb_r[i];
  end

  // stage D: sums, shift and saturate
  logic [tsw_pkg::OUT_TDATA_W-1:0] data_nxt;
  logic [P+1:0]                    acc;

  always_comb begin
    data_nxt = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = (P+2)'(basep_r[ch][0]) + (P+2)'(basep_r[ch][1]) + (P+2)'(basep_r[ch][2]);
      data_nxt[8*ch +: 8] = (|acc[P+1:24]) ? 8'hFF : acc[23:16];
      acc = '0;
      for (int i = 0; i < tsw_pkg::NUM_MAT; i++) acc = acc + (P+2)'(splatp_r[ch][i]);
      data_nxt[24+8*ch +: 8] = (|acc[P+1:24]) ? 8'hFF : acc[23:16];
    end
    for (int i = 0; i < tsw_pkg::NUM_MAT; i++)
      data_nxt[48+8*i +: 8] = (|wp_r[i][P-1:24]) ? 8'hFF : wp_r[i][23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
      vld_r <= 1'b0;
    end else if (en) begin
      va_r  <= vld;
      vb_r  <= va_r;
      vc_r  <= vb_r;
      vld_r <= vc_r;
    end
    if (en) begin
      ka_r     <= pix.k;
      texa_r   <= pix.tex;
      ba_r     <= pb[2*Q-2:16];
      ca_r     <= pc[2*Q-2:16];
      sa_r     <= s_nxt;
      kb_r     <= ka_r;
      texb_r   <= texa_r;
      bb_r     <= ba_r;
      cb_r     <= ca_r;
      sb_r     <= sa_r;
      wb_r     <= w_nxt;
      basep_r  <= basep_nxt;
      splatp_r <= splatp_nxt;
      wp_r     <= wp_nxt;
      data_r   <= data_nxt;
    end
  end

endmodule

// ===== design/terrain_splat_weight_blender.sv =====
// Top level of the terrain splat weight blender: registers, pipeline and handshakes.
// Path from an input transfer to its result on out_tvalid: band search, four
// divider stages of four quotient bits, then slope mix, weights, products and
// saturating sums, each stage registered.
// Throughput: one pixel per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n low, synchronous): pipeline emptied, bounds 0/21845/43690/65535,
// material colours 0.
module terrain_splat_weight_blender (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // height, normal_up, texel_0, texel_1, texel_2, texel_3 (lowest first)
  input  logic [tsw_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // base_red, base_green, base_blue, splat_red, splat_green, splat_blue,
  // weight_0, weight_1, weight_2, weight_3 (lowest first)
  output logic [tsw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tsw_pkg::RGB_BITS-1:0]        cfg_data
);

  localparam int HB = tsw_pkg::HEIGHT_BITS;
  localparam int DS = tsw_pkg::DIV_STAGES;

  logic [tsw_pkg::NUM_MAT-1:0][HB-1:0]                bound_r;
  logic [tsw_pkg::NUM_MAT-1:0][tsw_pkg::RGB_BITS-1:0] colour_r;
  logic                                               en;
  logic [DS:0]                                        vld;
  tsw_pkg::pix_t                                      pix [DS+1];
  tsw_pkg::texels_t                                   tex_in;

  // Advance every stage whenever the output register is free or being drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < tsw_pkg::NUM_MAT; i++)
      tex_in[i] = in_tdata[tsw_pkg::IN_T_LSB + tsw_pkg::RGB_BITS*i +: tsw_pkg::RGB_BITS];
  end

  // Configuration registers; indexes beyond the list drop the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r[0]  <= HB'(0);
      bound_r[1]  <= HB'(21845);
      bound_r[2]  <= HB'(43690);
      bound_r[3]  <= HB'(65535);
      colour_r    <= '0;
    end else if (cfg_valid) begin
      if (cfg_index <= tsw_pkg::REG_BOUND_3)
        bound_r[cfg_index[1:0]] <= HB'(cfg_data[15:0]);
      else if (cfg_index >= tsw_pkg::REG_COLOUR_0 && cfg_index <= tsw_pkg::REG_COLOUR_3)
        colour_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  tsw_band u_band (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_tvalid),
    .height (in_tdata[tsw_pkg::IN_H_LSB +: HB]),
    .nrm    (in_tdata[tsw_pkg::IN_N_LSB +: tsw_pkg::NRM_BITS]),
    .tex    (tex_in),
    .bound  (bound_r),
    .vld_r  (vld[0]),
    .pix_r  (pix[0])
  );

  // Divider chain for t
  for (genvar g = 0; g < DS; g++) begin : g_div
    tsw_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld   (vld[g]),
      .pix   (pix[g]),
      .vld_r (vld[g+1]),
      .pix_r (pix[g+1])
    );
  end

  tsw_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld    (vld[DS]),
    .pix    (pix[DS]),
    .colour (colour_r),
    .vld_r  (out_tvalid),
    .data_r (out_tdata)
  );

endmodule
